[sv/lgrs_pkg.sv]
// Shared types and constants for the Life generation row step unit.
`timescale 1ns / 1ps
`default_nettype none

package lgrs_pkg;

  localparam int unsigned MaxColumns = 64;
  localparam int unsigned RowWidth   = 64;
  localparam int unsigned WidthBits  = 7;
  localparam logic [WidthBits-1:0] WidthReset = 7'd64;

  localparam int unsigned OutqDepth = 4;
  localparam int unsigned OutqPtrW  = $clog2(OutqDepth);
  localparam int unsigned OutqCntW  = $clog2(OutqDepth + 1);

  typedef struct packed {
    logic [RowWidth-1:0] row_cells;
    logic                last_row;
  } in_item_t;

  typedef struct packed {
    logic [RowWidth-1:0] next_row_cells;
    logic                grid_done;
  } out_item_t;

  typedef struct packed {
    logic update;
    logic mid_valid;
    logic clear;
  } cell_ctrl_t;

  typedef struct packed {
    logic above;
    logic middle;
    logic current;
  } col_bits_t;

  typedef struct packed {
    logic push_a;
    logic push_b;
  } outq_push_t;

endpackage

`default_nettype wire

[sv/lgrs_cell.sv]
// One grid column: holds the column's two stored rows and computes its next state.
`timescale 1ns / 1ps
`default_nettype none

module lgrs_cell (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire lgrs_pkg::cell_ctrl_t ctrl_i,
  input  wire logic               col_en_i,
  input  wire logic               row_bit_i,
  input  wire lgrs_pkg::col_bits_t  left_i,
  input  wire lgrs_pkg::col_bits_t  right_i,
  output lgrs_pkg::col_bits_t       own_o,
  output logic                    next_a_o,
  output logic                    next_b_o
);

  logic above_q, above_d;
  logic mid_q, mid_d;
  logic [3:0] cnt_a;
  logic [2:0] cnt_b;

  assign own_o.above   = above_q & col_en_i;
  assign own_o.middle  = mid_q & col_en_i & ctrl_i.mid_valid;
  assign own_o.current = row_bit_i & col_en_i;

  always_comb begin
    cnt_a = 4'(left_i.above) + 4'(own_o.above) + 4'(right_i.above)
          + 4'(left_i.middle) + 4'(right_i.middle)
          + 4'(left_i.current) + 4'(own_o.current) + 4'(right_i.current);
    cnt_b = 3'(left_i.middle) + 3'(own_o.middle) + 3'(right_i.middle)
          + 3'(left_i.current) + 3'(right_i.current);
  end

  assign next_a_o = col_en_i & ((cnt_a == 4'd3) | ((cnt_a == 4'd2) & own_o.middle));
  assign next_b_o = col_en_i & ((cnt_b == 3'd3) | ((cnt_b == 3'd2) & own_o.current));

  always_comb begin
    above_d = above_q;
    mid_d   = mid_q;
    if (ctrl_i.update) begin
      if (ctrl_i.clear) begin
        above_d = 1'b0;
        mid_d   = 1'b0;
      end else begin
        above_d = ctrl_i.mid_valid & mid_q;
        mid_d   = row_bit_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q <= 1'b0;
      mid_q   <= 1'b0;
    end else begin
      above_q <= above_d;
      mid_q   <= mid_d;
    end
  end

endmodule

`default_nettype wire

[sv/lgrs_outq.sv]
// Result queue that takes up to two items per cycle and delivers one per cycle while the output is not stalled.
`timescale 1ns / 1ps
`default_nettype none

module lgrs_outq (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lgrs_pkg::outq_push_t  push_i,
  input  wire lgrs_pkg::out_item_t   item_a_i,
  input  wire lgrs_pkg::out_item_t   item_b_i,
  output logic                       space_two_o,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output lgrs_pkg::out_item_t        out_item_o
);

  localparam int unsigned Depth = lgrs_pkg::OutqDepth;
  localparam int unsigned PtrW  = lgrs_pkg::OutqPtrW;
  localparam int unsigned CntW  = lgrs_pkg::OutqCntW;

  lgrs_pkg::out_item_t mem_q [Depth];
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      n_push;
  logic            pop;
  logic [PtrW-1:0] b_addr;

  assign n_push      = 2'(push_i.push_a) + 2'(push_i.push_b);
  assign out_valid_o = (count_q != '0);
  assign pop         = out_valid_o & ~out_stall_i;
  assign out_item_o  = mem_q[head_q];
  assign space_two_o = (count_q <= CntW'(Depth - 2));
  assign b_addr      = push_i.push_a ? tail_q + PtrW'(1) : tail_q;

  always_comb begin
    head_d  = head_q + PtrW'(pop);
    tail_d  = tail_q + PtrW'(n_push);
    count_d = count_q + CntW'(n_push) - CntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      mem_q[tail_q] <= item_a_i;
    end
    if (push_i.push_b) begin
      mem_q[b_addr] <= item_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("Result queue holds more items than its depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.push_a & push_i.push_b) |-> (count_q <= CntW'(Depth - 2)))
    else $error("Two items pushed without room for both.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n_push != 2'd0) |-> (count_q < CntW'(Depth)))
    else $error("Item pushed into a full result queue.");
`endif

endmodule

`default_nettype wire

[sv/life_generation_row_step_unit.sv]
// Life generation row step unit: one B3/S23 generation, one grid row per item.
// A row's result enters the output queue when the row below it is accepted (or with the row
// itself for the bottom row) and is offered once it reaches the queue head.
// Throughput: one input item per cycle; a grid of R rows gives R results, the bottom row of a
// multi-row grid two together; input stalls while over two wait in the four-entry queue.
// Reset: asynchronous, active low; clears the held rows and the queue, width returns to 64.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_row_step_unit #(
  parameter int unsigned MaxColumns = lgrs_pkg::MaxColumns
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [lgrs_pkg::WidthBits-1:0]      cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire lgrs_pkg::in_item_t                  in_item_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output lgrs_pkg::out_item_t                      out_item_o
);

  localparam int unsigned RowW = lgrs_pkg::RowWidth;

  logic [lgrs_pkg::WidthBits-1:0] width_q;
  logic                           mid_valid_q, mid_valid_d;
  logic                           accept;
  logic                           space_two;
  lgrs_pkg::cell_ctrl_t           ctrl;
  lgrs_pkg::col_bits_t            col_bits [MaxColumns+2];
  logic [RowW-1:0]                next_a;
  logic [RowW-1:0]                next_b;
  lgrs_pkg::outq_push_t           push;
  lgrs_pkg::out_item_t            item_a;
  lgrs_pkg::out_item_t            item_b;

  assign in_stall_o = ~space_two;
  assign accept     = in_valid_i & ~in_stall_o;

  assign ctrl.update    = accept;
  assign ctrl.mid_valid = mid_valid_q;
  assign ctrl.clear     = in_item_i.last_row;

  assign col_bits[0]            = '0;
  assign col_bits[MaxColumns+1] = '0;

  for (genvar k = 0; k < MaxColumns; k++) begin : g_col
    lgrs_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .col_en_i  (width_q > lgrs_pkg::WidthBits'(k)),
      .row_bit_i (in_item_i.row_cells[k]),
      .left_i    (col_bits[k]),
      .right_i   (col_bits[k+2]),
      .own_o     (col_bits[k+1]),
      .next_a_o  (next_a[k]),
      .next_b_o  (next_b[k])
    );
  end

  if (MaxColumns < RowW) begin : g_pad
    assign next_a[RowW-1:MaxColumns] = '0;
    assign next_b[RowW-1:MaxColumns] = '0;
  end

  assign push.push_a = accept & mid_valid_q;
  assign push.push_b = accept & in_item_i.last_row;

  assign item_a.next_row_cells = next_a;
  assign item_a.grid_done      = 1'b0;
  assign item_b.next_row_cells = next_b;
  assign item_b.grid_done      = 1'b1;

  assign mid_valid_d = accept ? ~in_item_i.last_row : mid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= lgrs_pkg::WidthReset;
      mid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        width_q <= cfg_wdata_i;
      end
      mid_valid_q <= mid_valid_d;
    end
  end

  lgrs_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .item_a_i    (item_a),
    .item_b_i    (item_b),
    .space_two_o (space_two),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept & in_item_i.last_row) |=> !mid_valid_q)
    else $error("A row is still held after the bottom row of a grid.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept & !in_item_i.last_row) |=> mid_valid_q)
    else $error("A row that is not the bottom row was not held.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept & !mid_valid_q & !in_item_i.last_row) |-> (push == '0))
    else $error("The top row of a grid produced a result.");
`endif

endmodule

`default_nettype wire

[tb/life_generation_row_step_unit_tb.sv]
// Testbench for the Life generation row step unit: directed and random grids.
`timescale 1ns / 1ps

module life_generation_row_step_unit_tb;

  localparam int unsigned StallLimit = 5000;
  localparam int unsigned DrainCycles = 4;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [lgrs_pkg::WidthBits-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  lgrs_pkg::in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  lgrs_pkg::out_item_t out_item_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned stall_cycles = 0;

  logic [lgrs_pkg::WidthBits-1:0] width_cfg = lgrs_pkg::WidthReset;
  logic [lgrs_pkg::RowWidth-1:0] above_row = '0;
  logic [lgrs_pkg::RowWidth-1:0] middle_row = '0;
  logic middle_held = 1'b0;
  lgrs_pkg::out_item_t expected_next_rows[$];

  life_generation_row_step_unit DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o(out_item_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [lgrs_pkg::RowWidth-1:0] row_mask();
    int unsigned cols;
    cols = (width_cfg > lgrs_pkg::MaxColumns) ? lgrs_pkg::MaxColumns : width_cfg;
    if (cols >= lgrs_pkg::RowWidth) begin
      return '1;
    end
    return (64'd1 << cols) - 64'd1;
  endfunction

  function automatic logic [lgrs_pkg::RowWidth-1:0] life_next_row(
      input logic [lgrs_pkg::RowWidth-1:0] up,
      input logic [lgrs_pkg::RowWidth-1:0] mid,
      input logic [lgrs_pkg::RowWidth-1:0] down);
    logic [lgrs_pkg::RowWidth-1:0] m;
    logic [lgrs_pkg::RowWidth-1:0] u;
    logic [lgrs_pkg::RowWidth-1:0] c;
    logic [lgrs_pkg::RowWidth-1:0] d;
    logic [lgrs_pkg::RowWidth-1:0] res;
    int unsigned n;
    m = row_mask();
    u = up & m;
    c = mid & m;
    d = down & m;
    res = '0;
    for (int k = 0; k < lgrs_pkg::RowWidth; k++) begin
      n = 0;
      n += u[k];
      n += d[k];
      if (k > 0) begin
        n += u[k-1];
        n += c[k-1];
        n += d[k-1];
      end
      if (k < lgrs_pkg::RowWidth - 1) begin
        n += u[k+1];
        n += c[k+1];
        n += d[k+1];
      end
      res[k] = (n == 3) || (n == 2 && c[k]);
    end
    return res & m;
  endfunction

  function automatic void predict_row_results(input lgrs_pkg::in_item_t item);
    lgrs_pkg::out_item_t res;
    if (middle_held) begin
      res.next_row_cells = life_next_row(above_row, middle_row, item.row_cells);
      res.grid_done = 1'b0;
      expected_next_rows.push_back(res);
      if (item.last_row) begin
        res.next_row_cells = life_next_row(middle_row, item.row_cells, '0);
        res.grid_done = 1'b1;
        expected_next_rows.push_back(res);
        above_row = '0;
        middle_row = '0;
        middle_held = 1'b0;
      end else begin
        above_row = middle_row;
        middle_row = item.row_cells;
      end
    end else if (item.last_row) begin
      res.next_row_cells = life_next_row('0, item.row_cells, '0);
      res.grid_done = 1'b1;
      expected_next_rows.push_back(res);
      above_row = '0;
      middle_row = '0;
    end else begin
      above_row = '0;
      middle_row = item.row_cells;
      middle_held = 1'b1;
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [lgrs_pkg::RowWidth-1:0] got,
                                 input logic [lgrs_pkg::RowWidth-1:0] want);
    $display("MISMATCH %s: got %h expected %h", what, got, want);
    mismatch_count++;
  endtask

  task automatic send_row(input lgrs_pkg::in_item_t item);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= item;
    do @(posedge clk_i); while (in_stall_o);
    predict_row_results(item);
  endtask

  task automatic send_grid_row(input logic [lgrs_pkg::RowWidth-1:0] cells, input logic last);
    lgrs_pkg::in_item_t item;
    item.row_cells = cells;
    item.last_row = last;
    send_row(item);
  endtask

  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_next_rows.size() != 0);
  endtask

  task automatic set_width(input logic [lgrs_pkg::WidthBits-1:0] cols);
    wait_for_drain();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= cols;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    width_cfg = cols;
  endtask

  function automatic logic [lgrs_pkg::RowWidth-1:0] random_row();
    logic [lgrs_pkg::RowWidth-1:0] a;
    logic [lgrs_pkg::RowWidth-1:0] b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return a & b;
      1: return a | b;
      2: return a & b & {$urandom, $urandom};
      3: return '0;
      4: return '1;
      default: return a;
    endcase
  endfunction

  function automatic logic [lgrs_pkg::WidthBits-1:0] pick_width();
    case ($urandom_range(9))
      0: return 7'd0;
      1: return 7'd1;
      2: return 7'd2;
      3: return 7'd3;
      4: return 7'd63;
      5: return 7'd65;
      6: return 7'd127;
      7: return lgrs_pkg::WidthBits'($urandom_range(62, 4));
      default: return 7'd64;
    endcase
  endfunction

  task automatic test_single_row_grids();
    send_grid_row('1, 1'b1);
    send_grid_row('0, 1'b1);
    send_grid_row(64'hAAAA_5555_F0F0_0F0F, 1'b1);
  endtask

  task automatic test_edge_blinkers();
    send_grid_row('0, 1'b0);
    send_grid_row(64'h8000_0000_0000_0001, 1'b0);
    send_grid_row(64'h8000_0000_0000_0001, 1'b0);
    send_grid_row(64'h8000_0000_0000_0001, 1'b0);
    send_grid_row(64'h0000_0000_0000_0000, 1'b1);
  endtask

  task automatic test_full_grid();
    send_grid_row('1, 1'b0);
    send_grid_row('1, 1'b0);
    send_grid_row('1, 1'b1);
  endtask

  task automatic test_width_extremes();
    set_width(7'd0);
    send_grid_row('1, 1'b1);
    set_width(7'd1);
    send_grid_row('1, 1'b0);
    send_grid_row(64'h3, 1'b1);
    set_width(7'd65);
    send_grid_row('1, 1'b1);
    set_width(7'd127);
    send_grid_row(64'hC000_0000_0000_0003, 1'b1);
  endtask

  task automatic test_width_mid_grid();
    set_width(7'd64);
    send_grid_row('1, 1'b0);
    set_width(7'd32);
    send_grid_row(64'hFFFF_FFFF_0000_FFFF, 1'b0);
    send_grid_row('1, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned sender_pct,
                                     input int unsigned receiver_pct,
                                     input int unsigned row_budget);
    int unsigned rows_sent;
    int unsigned grid_rows;
    lgrs_pkg::in_item_t item;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    rows_sent = 0;
    while (rows_sent < row_budget) begin
      if ($urandom_range(3) == 0) begin
        set_width(pick_width());
      end
      grid_rows = ($urandom_range(7) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
      for (int unsigned r = 0; r < grid_rows; r++) begin
        item.row_cells = random_row();
        item.last_row = (r == grid_rows - 1);
        send_row(item);
        rows_sent++;
        if (!item.last_row && $urandom_range(24) == 0) begin
          wait_for_drain();
        end
      end
    end
  endtask

  always @(posedge clk_i) begin : check_results
    lgrs_pkg::out_item_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_next_rows.size() == 0) begin
        report_mismatch("result with none expected", out_item_o.next_row_cells, '0);
      end else begin
        want = expected_next_rows.pop_front();
        if (out_item_o.next_row_cells !== want.next_row_cells) begin
          report_mismatch("next_row_cells", out_item_o.next_row_cells, want.next_row_cells);
        end
        if (out_item_o.grid_done !== want.grid_done) begin
          report_mismatch("grid_done", lgrs_pkg::RowWidth'(out_item_o.grid_done),
                          lgrs_pkg::RowWidth'(want.grid_done));
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("life_generation_row_step_unit_tb NOT OK");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 17;
    recv_idle_pct = 60;
    test_single_row_grids();
    test_edge_blinkers();
    test_full_grid();
    test_width_extremes();
    test_width_mid_grid();
    test_random_traffic(17, 60, 170);
    test_random_traffic(60, 17, 170);
    test_random_traffic(0, 0, 170);
    wait_for_drain();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("life_generation_row_step_unit_tb OK");
    end else begin
      $display("life_generation_row_step_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

[life_generation_row_step_unit.f]
sv/lgrs_pkg.sv
sv/lgrs_cell.sv
sv/lgrs_outq.sv
sv/life_generation_row_step_unit.sv
tb/life_generation_row_step_unit_tb.sv
